// File: rtl/swk_pkg.sv
// ----------------------------------------------------------------------------
// Swerve wheel kinematics package
// Widths, constants, pipeline records and the arctangent table shared by the
// swerve drive wheel kinematics block.
// ----------------------------------------------------------------------------
package swk_pkg;

  localparam int CMD_W      = 16;
  localparam int RATIO_W    = 16;
  localparam int SPD_W      = 16;
  localparam int ANG_W      = 16;
  localparam int LANES      = 4;
  localparam int TERM_W     = 18;
  localparam int PROD_W     = 33;
  localparam int SQ_W       = 36;
  localparam int SQRT_STEPS = 18;
  localparam int ROOT_W     = 18;
  localparam int REM_W      = 20;
  localparam int CX_W       = 34;
  localparam int Z_W        = 25;
  localparam int PRESHIFT   = 14;
  localparam int ATAN_LEN   = 24;
  localparam int DIV_STEPS  = 16;
  localparam int NUM_W      = 35;
  localparam int DEN_W      = 19;
  localparam int CFG_IDX_W  = 1;

  localparam int CORDIC_STAGES_DEF = 16;

  localparam logic [RATIO_W-1:0]      RATIO_RESET  = 16'd23170;
  localparam logic [ROOT_W-1:0]       ONE_Q15      = 18'd32768;
  localparam logic signed [Z_W-1:0]   QUARTER_TURN = 25'sd2304000;
  localparam logic signed [Z_W-1:0]   ANGLE_HALF   = 25'sd128;
  localparam logic signed [Z_W-1:0]   HALF_TURN    = 25'sd18000;
  localparam logic signed [PROD_W-1:0] PROD_HALF   = 33'sd16384;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LENGTH_RATIO = 1'b0,
    REG_WIDTH_RATIO  = 1'b1
  } cfg_reg_e;

  // One wheel inside the square-root and vectoring chain.
  typedef struct packed {
    logic signed [CX_W-1:0] cx;
    logic signed [CX_W-1:0] cy;
    logic signed [Z_W-1:0]  z;
    logic                   zero;
    logic [SQ_W-1:0]        sq;
    logic [ROOT_W-1:0]      root;
    logic [REM_W-1:0]       rem;
  } lane_t;

  typedef lane_t [LANES-1:0] vec_t;

  typedef struct packed {
    logic [ROOT_W-1:0]      spd;
    logic signed [ANG_W-1:0] ang;
  } wheel_t;

  typedef struct packed {
    logic [NUM_W-1:0] r;
    logic [SPD_W-1:0] q;
  } div_lane_t;

  typedef struct packed {
    div_lane_t [LANES-1:0] d;
    wheel_t [LANES-1:0]    w;
    logic [DEN_W-1:0]      den;
    logic                  big;
  } norm_t;

  // atan(2^-i) in 1/256 hundredths of a degree, rounded to nearest.
  function automatic logic signed [Z_W-1:0] atan_entry(input int unsigned idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      0:  v = 25'sd1152000;
      1:  v = 25'sd680069;
      2:  v = 25'sd359328;
      3:  v = 25'sd182400;
      4:  v = 25'sd91554;
      5:  v = 25'sd45822;
      6:  v = 25'sd22916;
      7:  v = 25'sd11459;
      8:  v = 25'sd5730;
      9:  v = 25'sd2865;
      10: v = 25'sd1432;
      11: v = 25'sd716;
      12: v = 25'sd358;
      13: v = 25'sd179;
      14: v = 25'sd90;
      15: v = 25'sd45;
      16: v = 25'sd22;
      17: v = 25'sd11;
      18: v = 25'sd6;
      19: v = 25'sd3;
      20: v = 25'sd1;
      21: v = 25'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/swk_if.sv
// ----------------------------------------------------------------------------
// Swerve wheel kinematics channels
// Command, result and register write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface swk_cmd_if;
  logic valid;
  logic ready;
  logic signed [swk_pkg::CMD_W-1:0] forward_cmd;
  logic signed [swk_pkg::CMD_W-1:0] strafe_cmd;
  logic signed [swk_pkg::CMD_W-1:0] rotate_cmd;
  modport source (output valid, forward_cmd, strafe_cmd, rotate_cmd, input ready);
  modport sink   (input valid, forward_cmd, strafe_cmd, rotate_cmd, output ready);
endinterface

interface swk_res_if;
  logic valid;
  logic ready;
  logic [swk_pkg::SPD_W-1:0]        speed_right_front;
  logic [swk_pkg::SPD_W-1:0]        speed_left_front;
  logic [swk_pkg::SPD_W-1:0]        speed_left_rear;
  logic [swk_pkg::SPD_W-1:0]        speed_right_rear;
  logic signed [swk_pkg::ANG_W-1:0] angle_right_front;
  logic signed [swk_pkg::ANG_W-1:0] angle_left_front;
  logic signed [swk_pkg::ANG_W-1:0] angle_left_rear;
  logic signed [swk_pkg::ANG_W-1:0] angle_right_rear;
  modport source (output valid, speed_right_front, speed_left_front, speed_left_rear,
                  speed_right_rear, angle_right_front, angle_left_front,
                  angle_left_rear, angle_right_rear, input ready);
  modport sink   (input valid, speed_right_front, speed_left_front, speed_left_rear,
                  speed_right_rear, angle_right_front, angle_left_front,
                  angle_left_rear, angle_right_rear, output ready);
endinterface

interface swk_cfg_if;
  logic valid;
  logic ready;
  logic [swk_pkg::CFG_IDX_W-1:0] index;
  logic [swk_pkg::RATIO_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/swk_front.sv
// ----------------------------------------------------------------------------
// Swerve wheel kinematics front end
// Ratio products, corner terms, squared magnitudes and the quarter-turn
// pre-rotation, in three pipeline stages.
// ----------------------------------------------------------------------------
module swk_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              v_i,
  output logic                              rdy_o,
  input  logic signed [swk_pkg::CMD_W-1:0]  fwd_i,
  input  logic signed [swk_pkg::CMD_W-1:0]  str_i,
  input  logic signed [swk_pkg::CMD_W-1:0]  rot_i,
  input  logic [swk_pkg::RATIO_W-1:0]       length_ratio_i,
  input  logic [swk_pkg::RATIO_W-1:0]       width_ratio_i,
  output logic                              v_o,
  input  logic                              rdy_i,
  output swk_pkg::vec_t                     d_o
);

  localparam int TW = swk_pkg::TERM_W;
  localparam int CW = swk_pkg::CX_W;
  localparam int PW = swk_pkg::PROD_W;

  logic a_v_q, b_v_q, c_v_q;
  logic a_rdy, b_rdy, c_rdy;

  logic signed [TW-1:0] rl_q, rw_q;
  logic signed [swk_pkg::CMD_W-1:0] fwd_q, str_q;
  logic signed [TW-1:0] x_q [swk_pkg::LANES];
  logic signed [TW-1:0] y_q [swk_pkg::LANES];
  swk_pkg::vec_t vec_q, vec_d;

  logic signed [PW-1:0] pl, pw;
  logic signed [TW-1:0] ea, eb, ec, ed, sf, ss;

  assign c_rdy = !c_v_q || rdy_i;
  assign b_rdy = !b_v_q || c_rdy;
  assign a_rdy = !a_v_q || b_rdy;
  assign rdy_o = a_rdy;
  assign v_o   = c_v_q;
  assign d_o   = vec_q;

  // Rounded half up: add one half LSB, then floor.
  assign pl = rot_i * $signed({1'b0, length_ratio_i}) + swk_pkg::PROD_HALF;
  assign pw = rot_i * $signed({1'b0, width_ratio_i}) + swk_pkg::PROD_HALF;

  assign sf = TW'(fwd_q);
  assign ss = TW'(str_q);
  assign ea = ss - rl_q;
  assign eb = ss + rl_q;
  assign ec = sf - rw_q;
  assign ed = sf + rw_q;

  always_comb begin
    for (int k = 0; k < swk_pkg::LANES; k++) begin
      logic signed [2*TW-1:0] xx, yy;
      logic signed [CW-1:0]   cx0, cy0;
      xx = x_q[k] * x_q[k];
      yy = y_q[k] * y_q[k];
      cx0 = {{(CW-TW-swk_pkg::PRESHIFT){x_q[k][TW-1]}}, x_q[k],
             {swk_pkg::PRESHIFT{1'b0}}};
      cy0 = {{(CW-TW-swk_pkg::PRESHIFT){y_q[k][TW-1]}}, y_q[k],
             {swk_pkg::PRESHIFT{1'b0}}};
      vec_d[k].sq   = $unsigned(xx) + $unsigned(yy);
      vec_d[k].root = '0;
      vec_d[k].rem  = '0;
      vec_d[k].zero = (x_q[k] == '0) && (y_q[k] == '0);
      vec_d[k].cx   = cx0;
      vec_d[k].cy   = cy0;
      vec_d[k].z    = '0;
      // A left half plane vector is turned a quarter towards the right half.
      if (x_q[k] < 0) begin
        if (y_q[k] >= 0) begin
          vec_d[k].cx = cy0;
          vec_d[k].cy = -cx0;
          vec_d[k].z  = swk_pkg::QUARTER_TURN;
        end else begin
          vec_d[k].cx = -cy0;
          vec_d[k].cy = cx0;
          vec_d[k].z  = -swk_pkg::QUARTER_TURN;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
    end else begin
      if (a_rdy) a_v_q <= v_i;
      if (b_rdy) b_v_q <= a_v_q;
      if (c_rdy) c_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_rdy) begin
      rl_q  <= pl[PW-1:15];
      rw_q  <= pw[PW-1:15];
      fwd_q <= fwd_i;
      str_q <= str_i;
    end
    if (b_rdy) begin
      // Wheel order: right front, left front, left rear, right rear.
      y_q[0] <= eb; x_q[0] <= ec;
      y_q[1] <= eb; x_q[1] <= ed;
      y_q[2] <= ea; x_q[2] <= ed;
      y_q[3] <= ea; x_q[3] <= ec;
    end
    if (c_rdy) vec_q <= vec_d;
  end

endmodule

// File: rtl/swk_vec_cell.sv
// ----------------------------------------------------------------------------
// Swerve wheel kinematics vector cell
// One square-root digit and/or one vectoring rotation for all four wheels.
// ----------------------------------------------------------------------------
module swk_vec_cell #(
  parameter int STEP          = 0,
  parameter int CORDIC_STAGES = swk_pkg::CORDIC_STAGES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          v_i,
  output logic          rdy_o,
  input  swk_pkg::vec_t d_i,
  output logic          v_o,
  input  logic          rdy_i,
  output swk_pkg::vec_t d_o
);

  localparam int RW = swk_pkg::REM_W;
  localparam int QW = swk_pkg::ROOT_W;

  logic          v_q;
  swk_pkg::vec_t d_q, d_d;

  assign rdy_o = !v_q || rdy_i;
  assign v_o   = v_q;
  assign d_o   = d_q;

  for (genvar k = 0; k < swk_pkg::LANES; k++) begin : g_step
    logic [RW+1:0]       cur;
    logic [RW+1:0]       trial;
    logic signed [swk_pkg::CX_W-1:0] dx, dy;

    if (STEP < swk_pkg::SQRT_STEPS) begin : g_sqrt
      localparam int BI = swk_pkg::SQRT_STEPS - 1 - STEP;
      assign cur   = {d_i[k].rem, d_i[k].sq[2*BI+1 -: 2]};
      assign trial = {2'b00, d_i[k].root, 2'b01};
    end else begin : g_nosqrt
      assign cur   = '0;
      assign trial = '0;
    end

    if ((STEP < CORDIC_STAGES) && (STEP < swk_pkg::ATAN_LEN)) begin : g_rot
      assign dx = d_i[k].cy >>> STEP;
      assign dy = d_i[k].cx >>> STEP;
    end else begin : g_norot
      assign dx = '0;
      assign dy = '0;
    end

    always_comb begin
      d_d[k] = d_i[k];
      if (STEP < swk_pkg::SQRT_STEPS) begin
        if (cur >= trial) begin
          d_d[k].rem  = RW'(cur - trial);
          d_d[k].root = {d_i[k].root[QW-2:0], 1'b1};
        end else begin
          d_d[k].rem  = cur[RW-1:0];
          d_d[k].root = {d_i[k].root[QW-2:0], 1'b0};
        end
      end
      if ((STEP < CORDIC_STAGES) && (STEP < swk_pkg::ATAN_LEN)) begin
        // Positive y turns clockwise, anything else counterclockwise.
        if (d_i[k].cy > 0) begin
          d_d[k].cx = d_i[k].cx + dx;
          d_d[k].cy = d_i[k].cy - dy;
          d_d[k].z  = d_i[k].z + swk_pkg::atan_entry(STEP);
        end else begin
          d_d[k].cx = d_i[k].cx - dx;
          d_d[k].cy = d_i[k].cy + dy;
          d_d[k].z  = d_i[k].z - swk_pkg::atan_entry(STEP);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (rdy_o) begin
      v_q <= v_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o) d_q <= d_d;
  end

endmodule

// File: rtl/swk_norm_cell.sv
// ----------------------------------------------------------------------------
// Swerve wheel kinematics normalisation cell
// One quotient bit of the speed scaling division for all four wheels.
// ----------------------------------------------------------------------------
module swk_norm_cell #(
  parameter int STEP = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           v_i,
  output logic           rdy_o,
  input  swk_pkg::norm_t d_i,
  output logic           v_o,
  input  logic           rdy_i,
  output swk_pkg::norm_t d_o
);

  localparam int NW  = swk_pkg::NUM_W;
  localparam int BIT = swk_pkg::DIV_STEPS - 1 - STEP;

  logic           v_q;
  swk_pkg::norm_t d_q, d_d;
  logic [NW-1:0]  shd;

  assign rdy_o = !v_q || rdy_i;
  assign v_o   = v_q;
  assign d_o   = d_q;
  assign shd   = NW'(d_i.den) << BIT;

  always_comb begin
    d_d = d_i;
    for (int k = 0; k < swk_pkg::LANES; k++) begin
      if (d_i.d[k].r >= shd) begin
        d_d.d[k].r      = d_i.d[k].r - shd;
        d_d.d[k].q[BIT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (rdy_o) begin
      v_q <= v_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o) d_q <= d_d;
  end

endmodule

// File: rtl/swerve_drive_wheel_kinematics.sv
// Throughput: one command per cycle while the result side keeps accepting;
// every stage is a register cell with its own valid bit.
// The square-root digit chain and the division chain set the depth, one bit per cell.
// A stalled result holds each full cell back to the first empty one, which keeps accepting.
// Reset clears all valid bits and sets both ratio registers to 23170.
// ----------------------------------------------------------------------------
// Swerve drive wheel kinematics
// Four-wheel inverse kinematics: wheel speeds by integer square root and
// normalisation, wheel angles by a vectoring rotation chain.
// ----------------------------------------------------------------------------
module swerve_drive_wheel_kinematics #(
  parameter int CORDIC_STAGES = swk_pkg::CORDIC_STAGES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  swk_cmd_if.sink        cmd_i,
  swk_res_if.source      res_o,
  swk_cfg_if.sink        cfg_i
);

  localparam int NCELLS = (CORDIC_STAGES > swk_pkg::SQRT_STEPS) ?
                          CORDIC_STAGES : swk_pkg::SQRT_STEPS;
  localparam int LN = swk_pkg::LANES;
  localparam int DS = swk_pkg::DIV_STEPS;

  logic [swk_pkg::RATIO_W-1:0] length_ratio_q, width_ratio_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_ratio_q <= swk_pkg::RATIO_RESET;
      width_ratio_q  <= swk_pkg::RATIO_RESET;
    end else if (cfg_i.valid) begin
      unique case (swk_pkg::cfg_reg_e'(cfg_i.index))
        swk_pkg::REG_LENGTH_RATIO: length_ratio_q <= cfg_i.data;
        swk_pkg::REG_WIDTH_RATIO:  width_ratio_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Vector chain.
  logic          cv  [NCELLS+1];
  logic          crd [NCELLS+1];
  swk_pkg::vec_t cd  [NCELLS+1];

  swk_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .v_i            (cmd_i.valid),
    .rdy_o          (cmd_i.ready),
    .fwd_i          (cmd_i.forward_cmd),
    .str_i          (cmd_i.strafe_cmd),
    .rot_i          (cmd_i.rotate_cmd),
    .length_ratio_i (length_ratio_q),
    .width_ratio_i  (width_ratio_q),
    .v_o            (cv[0]),
    .rdy_i          (crd[0]),
    .d_o            (cd[0])
  );

  for (genvar s = 0; s < NCELLS; s++) begin : g_vec
    swk_vec_cell #(
      .STEP          (s),
      .CORDIC_STAGES (CORDIC_STAGES)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .v_i    (cv[s]),
      .rdy_o  (crd[s]),
      .d_i    (cd[s]),
      .v_o    (cv[s+1]),
      .rdy_i  (crd[s+1]),
      .d_o    (cd[s+1])
    );
  end

  // Rounding of root and angle.
  logic                    r1_v_q, r1_rdy;
  swk_pkg::wheel_t [LN-1:0] r1_q, r1_d;

  always_comb begin
    for (int k = 0; k < LN; k++) begin
      logic signed [swk_pkg::Z_W-1:0] zr;
      zr = (cd[NCELLS][k].z + swk_pkg::ANGLE_HALF) >>> 8;
      if (zr > swk_pkg::HALF_TURN)       zr = swk_pkg::HALF_TURN;
      else if (zr < -swk_pkg::HALF_TURN) zr = -swk_pkg::HALF_TURN;
      r1_d[k].ang = cd[NCELLS][k].zero ? '0 : zr[swk_pkg::ANG_W-1:0];
      r1_d[k].spd = cd[NCELLS][k].root +
                    swk_pkg::ROOT_W'({cd[NCELLS][k].rem > {2'b00, cd[NCELLS][k].root}});
    end
  end

  // Largest speed.
  logic                    r2_v_q, r2_rdy;
  swk_pkg::wheel_t [LN-1:0] r2_w_q;
  logic [swk_pkg::ROOT_W-1:0] r2_mx_q, mx01, mx23, mx_d;

  assign mx01 = (r1_q[1].spd > r1_q[0].spd) ? r1_q[1].spd : r1_q[0].spd;
  assign mx23 = (r1_q[3].spd > r1_q[2].spd) ? r1_q[3].spd : r1_q[2].spd;
  assign mx_d = (mx23 > mx01) ? mx23 : mx01;

  // Division set-up: s*32768/m rounded half up is (s*65536 + m) / (2m).
  logic           r3_v_q, r3_rdy;
  swk_pkg::norm_t r3_q, r3_d;

  always_comb begin
    r3_d.w   = r2_w_q;
    r3_d.den = {r2_mx_q, 1'b0};
    r3_d.big = r2_mx_q > swk_pkg::ONE_Q15;
    for (int k = 0; k < LN; k++) begin
      r3_d.d[k].r = {1'b0, r2_w_q[k].spd, {DS{1'b0}}} +
                    {{(swk_pkg::NUM_W-swk_pkg::ROOT_W){1'b0}}, r2_mx_q};
      r3_d.d[k].q = '0;
    end
  end

  logic           nv  [DS+1];
  logic           nrd [DS+1];
  swk_pkg::norm_t nd  [DS+1];

  assign r3_rdy = !r3_v_q || nrd[0];
  assign r2_rdy = !r2_v_q || r3_rdy;
  assign r1_rdy = !r1_v_q || r2_rdy;
  assign crd[NCELLS] = r1_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1_v_q <= 1'b0;
      r2_v_q <= 1'b0;
      r3_v_q <= 1'b0;
    end else begin
      if (r1_rdy) r1_v_q <= cv[NCELLS];
      if (r2_rdy) r2_v_q <= r1_v_q;
      if (r3_rdy) r3_v_q <= r2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r1_rdy) r1_q <= r1_d;
    if (r2_rdy) begin
      r2_w_q  <= r1_q;
      r2_mx_q <= mx_d;
    end
    if (r3_rdy) r3_q <= r3_d;
  end

  assign nv[0] = r3_v_q;
  assign nd[0] = r3_q;

  for (genvar s = 0; s < DS; s++) begin : g_norm
    swk_norm_cell #(
      .STEP (s)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .v_i    (nv[s]),
      .rdy_o  (nrd[s]),
      .d_i    (nd[s]),
      .v_o    (nv[s+1]),
      .rdy_i  (nrd[s+1]),
      .d_o    (nd[s+1])
    );
  end

  assign nrd[DS]     = res_o.ready;
  assign res_o.valid = nv[DS];

  // Without normalisation every speed is already within 0 to 1.0.
  logic [swk_pkg::SPD_W-1:0] spd_out [LN];
  always_comb begin
    for (int k = 0; k < LN; k++) begin
      spd_out[k] = nd[DS].big ? nd[DS].d[k].q : nd[DS].w[k].spd[swk_pkg::SPD_W-1:0];
    end
  end

  assign res_o.speed_right_front = spd_out[0];
  assign res_o.speed_left_front  = spd_out[1];
  assign res_o.speed_left_rear   = spd_out[2];
  assign res_o.speed_right_rear  = spd_out[3];
  assign res_o.angle_right_front = nd[DS].w[0].ang;
  assign res_o.angle_left_front  = nd[DS].w[1].ang;
  assign res_o.angle_left_rear   = nd[DS].w[2].ang;
  assign res_o.angle_right_rear  = nd[DS].w[3].ang;

endmodule
